>>> sv/spi_mse_pkg.sv
package spi_mse_pkg;

   localparam int WORD_W = 16;
   localparam int DIV_W  = 16;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_CLOCK_POLARITY = 2'd0;
   localparam csr_index_type CSR_CPHA           = 2'd1;
   localparam csr_index_type CSR_MSB_FIRST      = 2'd2;
   localparam csr_index_type CSR_CLOCK_DIVIDER  = 2'd3;

   localparam logic [DIV_W-1:0] DIVIDER_RESET = 16'd2;

   typedef struct packed {
      logic             clock_polarity;
      logic             cpha;
      logic             msb_first;
      logic [DIV_W-1:0] clock_divider;
   } cfg_type;

   typedef struct packed {
      logic              mode;
      logic [WORD_W-1:0] tx_word;
      logic              long_word;
      logic              miso_level;
   } req_type;

   typedef struct packed {
      logic              sclk_level;
      logic              mosi_level;
      logic              busy_res;
      logic              done_res;
      logic [WORD_W-1:0] rx_word;
   } res_type;

   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_START = 1'b1;

   typedef logic [1:0] quarter_type;

   localparam quarter_type QTR_IDLE_LEAD = 2'd0;
   localparam quarter_type QTR_IDLE_EDGE = 2'd1;
   localparam quarter_type QTR_ACT_LEAD  = 2'd2;
   localparam quarter_type QTR_ACT_EDGE  = 2'd3;

endpackage

>>> sv/spi_mse_csr.sv
module spi_mse_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  spi_mse_pkg::csr_index_type csr_index,
   input  logic [15:0]               csr_wdata,
   output spi_mse_pkg::cfg_type      cfg
);
   import spi_mse_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CLOCK_POLARITY: cfg_in.clock_polarity = csr_wdata[0];
            CSR_CPHA:           cfg_in.cpha           = csr_wdata[0];
            CSR_MSB_FIRST:      cfg_in.msb_first      = csr_wdata[0];
            CSR_CLOCK_DIVIDER:  cfg_in.clock_divider  = csr_wdata[DIV_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_polarity <= 1'b0;
         cfg_ff.cpha           <= 1'b0;
         cfg_ff.msb_first      <= 1'b0;
         cfg_ff.clock_divider  <= DIVIDER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/spi_mse_engine.sv
module spi_mse_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  spi_mse_pkg::req_type item,
   input  spi_mse_pkg::cfg_type cfg,
   output spi_mse_pkg::res_type res
);
   import spi_mse_pkg::*;

   logic              active_ff,    active_in;
   quarter_type       quarter_ff,   quarter_in;
   logic [3:0]        bit_count_ff, bit_count_in;
   logic [DIV_W-1:0]  tick_ff,      tick_in;
   logic [WORD_W-1:0] tx_shift_ff,  tx_shift_in;
   logic [WORD_W-1:0] rx_shift_ff,  rx_shift_in;
   logic              is_long_ff,   is_long_in;
   logic              mosi_ff,      mosi_in;

   logic [DIV_W-2:0]  quarter_len;
   logic [DIV_W-1:0]  tick_inc;
   logic              quarter_end;
   logic [3:0]        last_bit;
   logic [3:0]        bit_pos;
   logic [WORD_W-1:0] rx_sampled;
   logic              done;

   // quarter length, never below one tick
   assign quarter_len = (cfg.clock_divider[DIV_W-1:1] == '0) ? (DIV_W-1)'(1)
                                                              : cfg.clock_divider[DIV_W-1:1];
   assign tick_inc    = tick_ff + DIV_W'(1);
   assign quarter_end = tick_inc >= {1'b0, quarter_len};
   assign last_bit    = {is_long_ff, 3'b111};
   assign bit_pos     = cfg.msb_first ? (last_bit - bit_count_ff) : bit_count_ff;

   always_comb begin
      if (cfg.msb_first) begin
         rx_sampled = is_long_ff ? {rx_shift_ff[WORD_W-2:0], item.miso_level}
                                 : {8'h00, rx_shift_ff[6:0], item.miso_level};
      end else begin
         rx_sampled = is_long_ff ? {item.miso_level, rx_shift_ff[WORD_W-1:1]}
                                 : {8'h00, item.miso_level, rx_shift_ff[7:1]};
      end
   end

   always_comb begin
      active_in    = active_ff;
      quarter_in   = quarter_ff;
      bit_count_in = bit_count_ff;
      tick_in      = tick_ff;
      tx_shift_in  = tx_shift_ff;
      rx_shift_in  = rx_shift_ff;
      is_long_in   = is_long_ff;
      mosi_in      = mosi_ff;
      done         = 1'b0;
      if (item.mode == MODE_START) begin
         if (!active_ff) begin
            is_long_in   = item.long_word;
            tx_shift_in  = item.long_word ? item.tx_word : {8'h00, item.tx_word[7:0]};
            rx_shift_in  = '0;
            active_in    = 1'b1;
            quarter_in   = QTR_IDLE_LEAD;
            bit_count_in = '0;
            tick_in      = '0;
         end
      end else if (active_ff) begin
         tick_in = tick_inc;
         if (quarter_end) begin
            tick_in = '0;
            case (quarter_ff)
               QTR_IDLE_LEAD: if (!cfg.cpha) mosi_in = tx_shift_ff[bit_pos];
               QTR_IDLE_EDGE: if (cfg.cpha)  mosi_in = tx_shift_ff[bit_pos];
               QTR_ACT_LEAD:  if (!cfg.cpha) rx_shift_in = rx_sampled;
               QTR_ACT_EDGE:  if (cfg.cpha)  rx_shift_in = rx_sampled;
               default:       mosi_in = mosi_ff;
            endcase
            if (quarter_ff == QTR_ACT_EDGE) begin
               quarter_in = QTR_IDLE_LEAD;
               if (bit_count_ff >= last_bit) begin
                  active_in    = 1'b0;
                  bit_count_in = '0;
                  done         = 1'b1;
               end else begin
                  bit_count_in = bit_count_ff + 4'd1;
               end
            end else begin
               quarter_in = quarter_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         quarter_ff   <= QTR_IDLE_LEAD;
         bit_count_ff <= '0;
         tick_ff      <= '0;
         tx_shift_ff  <= '0;
         rx_shift_ff  <= '0;
         is_long_ff   <= 1'b0;
         mosi_ff      <= 1'b0;
      end else if (fire) begin
         active_ff    <= active_in;
         quarter_ff   <= quarter_in;
         bit_count_ff <= bit_count_in;
         tick_ff      <= tick_in;
         tx_shift_ff  <= tx_shift_in;
         rx_shift_ff  <= rx_shift_in;
         is_long_ff   <= is_long_in;
         mosi_ff      <= mosi_in;
      end
   end

   // SCLK active in the upper two quarters only
   assign res.sclk_level = cfg.clock_polarity ^ (active_in & quarter_in[1]);
   assign res.mosi_level = mosi_in;
   assign res.busy_res   = active_in;
   assign res.done_res   = done;
   assign res.rx_word    = done ? rx_shift_in : '0;

endmodule

>>> sv/spi_master_shift_engine_top.sv
// SPI master shift engine: sends and receives one 8- or 16-bit word with
// selectable clock polarity, clock phase and bit order. Each request
// transaction is either one tick of time (carrying the sampled MISO level)
// or a start request; each yields exactly one response transaction with the
// SCLK and MOSI levels, busy, a done pulse and the right-aligned received
// word (zero unless done). A bit spans four quarters of
// max(clock_divider >> 1, 1) ticks. CPHA 0 drives MOSI at the end of quarter
// 0 and samples at the end of quarter 2; CPHA 1 drives on the leading edge and
// samples on the trailing edge. Starts while busy are ignored. Throughput is
// one transaction per clock while the response side does not stall; a request
// passes through the input register, then the step logic into the response
// register, before its response is valid. Configuration is live and should
// only be written while idle.
module spi_master_shift_engine_top (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_mode,
   input  logic [15:0]                req_tx_word,
   input  logic                       req_long_word,
   input  logic                       req_miso_level,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_sclk_level,
   output logic                       rsp_mosi_level,
   output logic                       rsp_busy_res,
   output logic                       rsp_done_res,
   output logic [15:0]                rsp_rx_word,
   // configuration
   input  logic                       csr_wr_en,
   input  spi_mse_pkg::csr_index_type csr_index,
   input  logic [15:0]                csr_wdata
);
   import spi_mse_pkg::*;

   cfg_type cfg;
   req_type item_ff, item_in;
   res_type res, res_ff;
   logic    in_valid_ff, in_valid_in;
   logic    out_valid_ff, out_valid_in;
   logic    fire;
   logic    req_take;

   spi_mse_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // step on a held request if the response register is empty or draining
   assign fire      = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~fire;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      item_in.mode       = req_mode;
      item_in.tx_word    = req_tx_word;
      item_in.long_word  = req_long_word;
      item_in.miso_level = req_miso_level;
   end

   assign in_valid_in  = req_take | (in_valid_ff & ~fire);
   assign out_valid_in = fire | (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (fire) begin
         res_ff <= res;
      end
   end

   spi_mse_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (item_ff),
      .cfg   (cfg),
      .res   (res)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_sclk_level = res_ff.sclk_level;
   assign rsp_mosi_level = res_ff.mosi_level;
   assign rsp_busy_res   = res_ff.busy_res;
   assign rsp_done_res   = res_ff.done_res;
   assign rsp_rx_word    = res_ff.rx_word;

   // a completing transaction always leaves the engine idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while still busy");

   // received word only shown on completion
   a_rx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_rx_word == '0)
      else $error("rx word non-zero without done");

   // every engine step produces a response
   a_fire_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("engine step lost its response");

   // the request side never stalls with an empty input register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("request stalled with empty input register");

endmodule

>>> tb/sv/spi_master_shift_engine_top_tb.sv
module spi_master_shift_engine_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import spi_mse_pkg::*;

   // Random phase stops once enough transactions have gone by
   localparam int ITEM_TARGET = 150;
   // Far above the slowest correct run
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_MAX  = 10;
   // Pipeline is an input register then a response register; settle time before touching registers
   localparam int SETTLE      = 8;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;

   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic                 req_mode       = MODE_TICK;
   logic [WORD_W-1:0]    req_tx_word    = '0;
   logic                 req_long_word  = 1'b0;
   logic                 req_miso_level = 1'b0;

   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic                 rsp_sclk_level;
   logic                 rsp_mosi_level;
   logic                 rsp_busy_res;
   logic                 rsp_done_res;
   logic [WORD_W-1:0]    rsp_rx_word;

   logic                 csr_wr_en      = 1'b0;
   csr_index_type        csr_index      = CSR_CLOCK_POLARITY;
   logic [DIV_W-1:0]     csr_wdata      = '0;

   // Shadow of the register file, as the engine should see it
   cfg_type              live_cfg;

   // Shift engine state mirrored by the predictor
   logic                 eng_active;
   quarter_type          eng_qtr;
   logic [3:0]           eng_bits;
   logic [15:0]          eng_ticks;
   logic [WORD_W-1:0]    eng_tx;
   logic [WORD_W-1:0]    eng_rx;
   logic                 eng_long;
   logic                 eng_mosi;

   res_type              expected_rsp[$];
   res_type              oldest;
   int unsigned          errors          = 0;
   int unsigned          items_sent      = 0;
   int unsigned          cycles          = 0;
   // When set, neither side inserts gaps or stalls
   bit                   steady          = 1'b0;

   spi_master_shift_engine_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_tx_word    (req_tx_word),
      .req_long_word  (req_long_word),
      .req_miso_level (req_miso_level),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sclk_level (rsp_sclk_level),
      .rsp_mosi_level (rsp_mosi_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_rx_word    (rsp_rx_word),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   // Advance the mirrored engine by one transaction and give the response it should produce
   task automatic predict_step(input req_type item, output res_type resp);
      logic [15:0] quarter_len;
      int          nbits;
      int          pos;
      logic [15:0] mask;
      resp = '0;
      if (item.mode == MODE_START) begin
         // a start while busy is dropped and no time passes
         if (!eng_active) begin
            eng_long   = item.long_word;
            eng_tx     = item.long_word ? item.tx_word : {8'h00, item.tx_word[7:0]};
            eng_rx     = '0;
            eng_active = 1'b1;
            eng_qtr    = QTR_IDLE_LEAD;
            eng_bits   = '0;
            eng_ticks  = '0;
         end
      end else if (eng_active) begin
         nbits       = eng_long ? 16 : 8;
         mask        = eng_long ? 16'hFFFF : 16'h00FF;
         quarter_len = live_cfg.clock_divider >> 1;
         if (quarter_len == 16'd0) quarter_len = 16'd1;
         eng_ticks = eng_ticks + 16'd1;
         // >= so a divider shrunk mid-quarter ends the quarter straight away
         if (eng_ticks >= quarter_len) begin
            eng_ticks = '0;
            if ((eng_qtr == QTR_IDLE_LEAD && !live_cfg.cpha) ||
                (eng_qtr == QTR_IDLE_EDGE &&  live_cfg.cpha)) begin
               pos      = live_cfg.msb_first ? nbits - 1 - int'(eng_bits) : int'(eng_bits);
               eng_mosi = eng_tx[pos];
            end
            if ((eng_qtr == QTR_ACT_LEAD && !live_cfg.cpha) ||
                (eng_qtr == QTR_ACT_EDGE &&  live_cfg.cpha)) begin
               if (live_cfg.msb_first)
                  eng_rx = ((eng_rx << 1) | {15'd0, item.miso_level}) & mask;
               else
                  eng_rx = ((eng_rx >> 1) | ({15'd0, item.miso_level} << (nbits - 1))) & mask;
            end
            if (eng_qtr == QTR_ACT_EDGE) begin
               eng_qtr = QTR_IDLE_LEAD;
               if (int'(eng_bits) + 1 >= nbits) begin
                  eng_active     = 1'b0;
                  eng_bits       = '0;
                  resp.done_res  = 1'b1;
                  resp.rx_word   = eng_rx;
               end else begin
                  eng_bits = eng_bits + 4'd1;
               end
            end else begin
               eng_qtr = eng_qtr + 2'd1;
            end
         end
      end
      resp.sclk_level = live_cfg.clock_polarity ^ (eng_active && eng_qtr >= QTR_ACT_LEAD);
      resp.mosi_level = eng_mosi;
      resp.busy_res   = eng_active;
   endtask

   function automatic req_type make_item(input logic m, input logic [15:0] word,
                                         input logic is_long, input logic miso);
      req_type item;
      item.mode       = m;
      item.tx_word    = word;
      item.long_word  = is_long;
      item.miso_level = miso;
      return item;
   endfunction

   function automatic req_type random_tick();
      return make_item(MODE_TICK, 16'($urandom), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
   endfunction

   // Offer one request transaction, hold it until taken, then log its expected response
   task automatic send_item(input req_type item);
      res_type resp;
      bit      ignored;
      if (!steady && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 35);
      end
      req_valid      <= 1'b1;
      req_mode       <= item.mode;
      req_tx_word    <= item.tx_word;
      req_long_word  <= item.long_word;
      req_miso_level <= item.miso_level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ignored = (item.mode == MODE_START) && eng_active;
      predict_step(item, resp);
      expected_rsp.push_back(resp);
      if (!ignored) items_sent++;
   endtask

   // Let every outstanding response come back so the engine is quiet
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [DIV_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_CLOCK_POLARITY: live_cfg.clock_polarity = data[0];
         CSR_CPHA:           live_cfg.cpha           = data[0];
         CSR_MSB_FIRST:      live_cfg.msb_first      = data[0];
         default:            live_cfg.clock_divider  = data;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly the fastest dividers (below 8) so that transfers stay short
   function automatic logic [DIV_W-1:0] pick_divider();
      if ($urandom_range(99) < 80) return DIV_W'($urandom_range(7));
      return DIV_W'($urandom_range(24, 8));
   endfunction

   // Single-bit registers get full random data; only bit 0 should count
   task automatic write_random_reg();
      case (csr_index_type'($urandom_range(3)))
         CSR_CLOCK_POLARITY: write_reg(CSR_CLOCK_POLARITY, DIV_W'($urandom));
         CSR_CPHA:           write_reg(CSR_CPHA, DIV_W'($urandom));
         CSR_MSB_FIRST:      write_reg(CSR_MSB_FIRST, DIV_W'($urandom));
         default:            write_reg(CSR_CLOCK_DIVIDER, pick_divider());
      endcase
   endtask

   task automatic randomise_config();
      write_reg(CSR_CLOCK_POLARITY, DIV_W'($urandom));
      write_reg(CSR_CPHA, DIV_W'($urandom));
      write_reg(CSR_MSB_FIRST, DIV_W'($urandom));
      write_reg(CSR_CLOCK_DIVIDER, pick_divider());
   endtask

   // One start, then ticks until the word completes; odd starts thrown in while busy
   task automatic run_transfer(input logic [15:0] word, input logic is_long,
                               input int busy_start_pct);
      send_item(make_item(MODE_START, word, is_long, 1'($urandom_range(1))));
      while (eng_active) begin
         if ($urandom_range(99) < busy_start_pct)
            send_item(make_item(MODE_START, 16'($urandom), 1'($urandom_range(1)),
                                1'($urandom_range(1))));
         else
            send_item(random_tick());
      end
   endtask

   // Ticks before any transfer: SCLK at idle level, MOSI still low from reset
   task automatic test_idle_ticks();
      send_item(make_item(MODE_TICK, 16'hFFFF, 1'b1, 1'b1));
      send_item(make_item(MODE_TICK, 16'h0000, 1'b0, 1'b0));
   endtask

   // Short word with all high bits set (must be dropped), plus a start while busy
   task automatic test_short_word_and_busy_start();
      logic miso;
      miso = 1'b0;
      send_item(make_item(MODE_START, 16'hFFFF, 1'b0, 1'b0));
      send_item(make_item(MODE_START, 16'h0000, 1'b1, 1'b1));
      while (eng_active) begin
         miso = ~miso;
         send_item(make_item(MODE_TICK, 16'h0000, 1'b0, miso));
      end
   endtask

   // Slowest divider, then shrink it mid-quarter; then the smallest divider values
   task automatic test_divider_extremes();
      drain_pipeline();
      write_reg(CSR_CLOCK_DIVIDER, 16'hFFFF);
      write_reg(CSR_MSB_FIRST, 16'h0001);
      write_reg(CSR_CLOCK_POLARITY, 16'h0001);
      write_reg(CSR_CPHA, 16'h0001);
      send_item(make_item(MODE_START, 16'h8001, 1'b1, 1'b0));
      repeat (4) send_item(random_tick());
      drain_pipeline();
      // tick count now beyond the new quarter length
      write_reg(CSR_CLOCK_DIVIDER, 16'h0000);
      while (eng_active) send_item(random_tick());
      drain_pipeline();
      write_reg(CSR_CLOCK_DIVIDER, 16'h0001);
      write_reg(CSR_CPHA, 16'h0000);
      run_transfer(16'h0000, 1'b1, 0);
   endtask

   // Back-to-back transactions on both channels across all clock modes
   task automatic test_no_idle_stretch();
      drain_pipeline();
      steady = 1'b1;
      for (int mode_sel = 0; mode_sel < 8; mode_sel++) begin
         drain_pipeline();
         write_reg(CSR_CLOCK_POLARITY, DIV_W'(mode_sel[0]));
         write_reg(CSR_CPHA, DIV_W'(mode_sel[1]));
         write_reg(CSR_MSB_FIRST, DIV_W'(mode_sel[2]));
         write_reg(CSR_CLOCK_DIVIDER, DIV_W'($urandom_range(3)));
         run_transfer(16'($urandom), 1'b0, 5);
      end
      drain_pipeline();
      steady = 1'b0;
   endtask

   // Mostly complete transfers with random content; some noise and
   // some register changes part-way through a word
   task automatic test_random_transfers();
      int unsigned base_items;
      int          choice;
      base_items = items_sent;
      drain_pipeline();
      randomise_config();
      while (items_sent - base_items < ITEM_TARGET) begin
         choice = $urandom_range(99);
         if (choice < 10) begin
            repeat ($urandom_range(6, 1))
               send_item(make_item(1'($urandom_range(1)), 16'($urandom),
                                   1'($urandom_range(1)), 1'($urandom_range(1))));
         end else if (choice < 22) begin
            send_item(make_item(MODE_START, 16'($urandom), 1'($urandom_range(1)), 1'b0));
            repeat ($urandom_range(20, 1)) send_item(random_tick());
            drain_pipeline();
            write_random_reg();
            while (eng_active) send_item(random_tick());
         end else begin
            run_transfer(16'($urandom), 1'($urandom_range(1)), 4);
         end
         if ($urandom_range(99) < 20) begin
            drain_pipeline();
            randomise_config();
         end
      end
   endtask

   // Response side: random stalls, and each taken response checked against the oldest expectation
   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= REPORT_MAX)
            $display("rsp %s: expected %h, got %h", field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 35);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("rsp transaction with none outstanding at cycle %0d", cycles);
         end else begin
            oldest = expected_rsp.pop_front();
            check_field("sclk_level", 16'(oldest.sclk_level), 16'(rsp_sclk_level));
            check_field("mosi_level", 16'(oldest.mosi_level), 16'(rsp_mosi_level));
            check_field("busy_res", 16'(oldest.busy_res), 16'(rsp_busy_res));
            check_field("done_res", 16'(oldest.done_res), 16'(rsp_done_res));
            check_field("rx_word", oldest.rx_word, rsp_rx_word);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      live_cfg   = '{clock_polarity: 1'b0, cpha: 1'b0, msb_first: 1'b0,
                     clock_divider: DIVIDER_RESET};
      eng_active = 1'b0;
      eng_qtr    = QTR_IDLE_LEAD;
      eng_bits   = '0;
      eng_ticks  = '0;
      eng_tx     = '0;
      eng_rx     = '0;
      eng_long   = 1'b0;
      eng_mosi   = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_ticks();
      test_short_word_and_busy_start();
      test_divider_extremes();
      test_no_idle_stretch();
      test_random_transfers();

      drain_pipeline();
      if (expected_rsp.size() != 0) errors++;
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
